/* hdl/l2c_pkg.sv */
// Shared types, key table and character helpers for the Latin-to-Cyrillic transliterator.
package l2c_pkg;

  localparam int WINDOW_DEF = 4;
  localparam int KEY_MAX    = 4;
  localparam int KEY_COUNT  = 40;
  localparam int UNIT_W     = 16;
  localparam int LEN_W      = 3;

  localparam logic [UNIT_W-1:0] CH_SPACE      = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_APOS       = 16'h0027;
  localparam logic [UNIT_W-1:0] CH_UNDERSCORE = 16'h005F;
  localparam logic [UNIT_W-1:0] CH_ACUTE      = 16'h00B4;

  // Key text, first character in the low byte; unused bytes are zero.
  localparam logic [31:0] KEY_TEXT [KEY_COUNT] = '{
    32'h00000061, 32'h00000062, 32'h00000076, 32'h00000067, 32'h00000064,
    32'h00000065, 32'h00006F6A, 32'h00006F79, 32'h0000687A, 32'h0000007A,
    32'h00000069, 32'h0000006A, 32'h0000006B, 32'h0000006C, 32'h0000006D,
    32'h0000006E, 32'h0000006F, 32'h00000070, 32'h00000072, 32'h00000073,
    32'h00000074, 32'h00000075, 32'h00000066, 32'h00000068, 32'h00000078,
    32'h00000063, 32'h00006873, 32'h00686373, 32'h00000077, 32'h68636873,
    32'h00006863, 32'h00000079, 32'h000000B4, 32'h00000027, 32'h00002765,
    32'h0000656A, 32'h0000756A, 32'h00007579, 32'h0000616A, 32'h00006179
  };

  localparam logic [LEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd1, 3'd4,
    3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
  };

  localparam logic [UNIT_W-1:0] KEY_LETTER [KEY_COUNT] = '{
    16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434,
    16'h0435, 16'h0451, 16'h0451, 16'h0436, 16'h0437,
    16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C,
    16'h043D, 16'h043E, 16'h043F, 16'h0440, 16'h0441,
    16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0445,
    16'h0446, 16'h0448, 16'h0449, 16'h0449, 16'h0449,
    16'h0447, 16'h044B, 16'h044A, 16'h044C, 16'h044D,
    16'h044D, 16'h044E, 16'h044E, 16'h044F, 16'h044F
  };

  typedef struct packed {
    logic              wr;
    logic [UNIT_W-1:0] data;
    logic              shift;
    logic [LEN_W-1:0]  len;
  } win_ctl_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [LEN_W-1:0]  len;
  } res_t;

  function automatic logic is_ascii_upper(input logic [UNIT_W-1:0] c);
    return (c >= 16'h0041) && (c <= 16'h005A);
  endfunction

  function automatic logic [UNIT_W-1:0] to_upper(input logic [UNIT_W-1:0] c);
    logic [UNIT_W-1:0] r;
    r = c;
    if ((c >= 16'h0061) && (c <= 16'h007A)) r = c - 16'h0020;
    else if ((c >= 16'h0430) && (c <= 16'h044F)) r = c - 16'h0020;
    else if ((c >= 16'h0450) && (c <= 16'h045F)) r = c - 16'h0050;
    return r;
  endfunction

endpackage

/* hdl/l2c_window.sv */
// Pending-unit window: append on input, shift left by the consumed key length.
module l2c_window #(
  parameter int WINDOW = l2c_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  l2c_pkg::win_ctl_t             ctl_i,
  output logic [l2c_pkg::UNIT_W-1:0]    head_o [l2c_pkg::KEY_MAX],
  output logic [$clog2(WINDOW+1)-1:0]   count_o
);
  import l2c_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = $clog2(WINDOW);

  logic [UNIT_W-1:0] units_q [WINDOW];
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (ctl_i.wr) count_d = count_q + CNT_W'(1);
    else if (ctl_i.shift) count_d = count_q - CNT_W'(ctl_i.len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else count_q <= count_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      units_q[count_q[IDX_W-1:0]] <= ctl_i.data;
    end else if (ctl_i.shift) begin
      for (int i = 0; i < WINDOW; i++) begin
        for (int k = 1; k <= KEY_MAX; k++) begin
          if ((i + k < WINDOW) && (ctl_i.len == LEN_W'(k))) units_q[i] <= units_q[i+k];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < KEY_MAX; j++) head_o[j] = units_q[j];
  end

  assign count_o = count_q;

endmodule

/* hdl/l2c_resolver.sv */
// Longest-key match against the head of the window; yields one unit and its length.
module l2c_resolver (
  input  logic [l2c_pkg::UNIT_W-1:0] head_i [l2c_pkg::KEY_MAX],
  input  logic [l2c_pkg::LEN_W-1:0]  avail_i,
  output l2c_pkg::res_t              res_o
);
  import l2c_pkg::*;

  logic [UNIT_W-1:0] lower [KEY_MAX];
  logic [KEY_MAX:1]  len_hit;
  logic [UNIT_W-1:0] len_letter [KEY_MAX+1];
  logic              key_hit;
  logic [UNIT_W-1:0] best;
  logic [LEN_W-1:0]  best_len;

  always_comb begin
    for (int j = 0; j < KEY_MAX; j++) begin
      lower[j] = is_ascii_upper(head_i[j]) ? head_i[j] + 16'h0020 : head_i[j];
    end
  end

  // Keys are distinct, so at most one key hits for each length.
  always_comb begin
    len_hit = '0;
    for (int l = 0; l <= KEY_MAX; l++) len_letter[l] = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      key_hit = (KEY_LEN[i] <= avail_i);
      for (int j = 0; j < KEY_MAX; j++) begin
        if (LEN_W'(j) < KEY_LEN[i]) begin
          if ((lower[j][15:8] != 8'h00) || (lower[j][7:0] != KEY_TEXT[i][8*j +: 8]))
            key_hit = 1'b0;
        end
      end
      for (int l = 1; l <= KEY_MAX; l++) begin
        if (key_hit && (KEY_LEN[i] == LEN_W'(l))) begin
          len_hit[l]    = 1'b1;
          len_letter[l] = len_letter[l] | KEY_LETTER[i];
        end
      end
    end
  end

  always_comb begin
    best     = '0;
    best_len = '0;
    for (int l = 1; l <= KEY_MAX; l++) begin
      if (len_hit[l]) begin
        best     = len_letter[l];
        best_len = LEN_W'(l);
      end
    end
    if (best_len == '0) begin
      res_o.unit = head_i[0];
      res_o.len  = LEN_W'(1);
    end else begin
      res_o.unit = is_ascii_upper(head_i[0]) ? to_upper(best) : best;
      res_o.len  = best_len;
    end
  end

endmodule

/* hdl/latin_to_cyrillic_transliterator.sv */
// Sequencing: an item whose window does not fill leaves no result and returns to idle.
// A full window takes one resolution per cycle through the shared key matcher, unless the
// output stalls with the hold stage occupied; an end-of-text item drains up to WINDOW resolutions.
// The last kept result of an item waits in a hold stage so flags can be set, then the
// output register; input is taken only when the sequencer is idle.
// Reset (async, active low) clears the window count, sequencer, hold and output valid, mode 0.
module latin_to_cyrillic_transliterator #(
  parameter int WINDOW = l2c_pkg::WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,       // filename_mode
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [l2c_pkg::UNIT_W-1:0]   s_axis_tdata_i,    // [15:0] in_char
  input  logic                         s_axis_tlast_i,    // in_last
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [l2c_pkg::UNIT_W-1:0]   m_axis_tdata_o,    // [15:0] out_char
  output logic                         m_axis_tlast_o,    // text_end
  output logic                         m_axis_tuser_o     // [0] run_last
);
  import l2c_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_RESOLVE = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic              fn_mode_q;
  logic              last_q, last_d;
  logic              hold_v_q, hold_v_d;
  logic [UNIT_W-1:0] hold_q, hold_d;
  logic              out_v_q, out_v_d;
  logic [UNIT_W-1:0] out_q, out_d;
  logic              out_end_q, out_end_d;
  logic              out_run_q, out_run_d;

  win_ctl_t          win_ctl;
  logic [UNIT_W-1:0] head [KEY_MAX];
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  avail;
  res_t              res;

  logic              in_acc, out_free, need, kept;
  logic [UNIT_W-1:0] clean;

  l2c_window #(.WINDOW(WINDOW)) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (win_ctl),
    .head_o  (head),
    .count_o (count)
  );

  assign avail = (count >= CNT_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : count[LEN_W-1:0];

  l2c_resolver u_resolver (
    .head_i  (head),
    .avail_i (avail),
    .res_o   (res)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_v_q || m_axis_tready_i;
  assign need            = (count == CNT_W'(WINDOW)) || (last_q && (count != '0));

  // File-name cleanup of a produced unit.
  always_comb begin
    kept  = 1'b1;
    clean = res.unit;
    if (fn_mode_q) begin
      kept  = (res.unit != CH_APOS) && (res.unit != CH_ACUTE);
      clean = to_upper((res.unit == CH_SPACE) ? CH_UNDERSCORE : res.unit);
    end
  end

  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    hold_v_d  = hold_v_q;
    hold_d    = hold_q;
    out_v_d   = out_v_q && !m_axis_tready_i;
    out_d     = out_q;
    out_end_d = out_end_q;
    out_run_d = out_run_q;
    win_ctl   = '{wr: in_acc, data: s_axis_tdata_i, shift: 1'b0, len: res.len};
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d  = s_axis_tlast_i;
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (need) begin
          if (!(kept && hold_v_q && !out_free)) begin
            win_ctl.shift = 1'b1;
            if (kept) begin
              if (hold_v_q) begin
                out_v_d   = 1'b1;
                out_d     = hold_q;
                out_end_d = 1'b0;
                out_run_d = 1'b0;
              end
              hold_v_d = 1'b1;
              hold_d   = clean;
            end
          end
        end else if (hold_v_q) begin
          if (out_free) begin
            out_v_d   = 1'b1;
            out_d     = hold_q;
            out_end_d = last_q;
            out_run_d = 1'b1;
            hold_v_d  = 1'b0;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fn_mode_q <= 1'b0;
      last_q    <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      last_q   <= last_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) fn_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q    <= hold_d;
    out_q     <= out_d;
    out_end_q <= out_end_d;
    out_run_q <= out_run_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_end_q;
  assign m_axis_tuser_o  = out_run_q;

`ifndef SYNTHESIS
  a_idle_no_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_v_q)
    else $error("hold stage still occupied while idle");

  a_idle_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (count < CNT_W'(WINDOW)))
    else $error("window full while accepting");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(WINDOW))
    else $error("window count overflow");

  a_accept_resolve : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RESOLVE))
    else $error("accepted transaction not resolved");

  a_end_is_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_end_q) |-> out_run_q)
    else $error("text end without run end");
`endif

endmodule

/* tb/sv/tb_latin_to_cyrillic_transliterator.sv */
// Self-checking stream testbench for the Latin-to-Cyrillic transliterator.
module tb_latin_to_cyrillic_transliterator;
  timeunit 1ns;
  timeprecision 1ps;
  import l2c_pkg::*;

  localparam int WIN         = 4;
  localparam int SETTLE      = WIN + 6;
  localparam int STALL_LIMIT = 2000;
  localparam int N_KEYS      = 40;
  localparam int RAND_ITEMS  = 76;
  localparam int N_PHASES    = 4;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {ROW_ITEM, ROW_MODE} row_kind_e;
  // where a directed row takes its expectation from
  typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} row_check_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [UNIT_W-1:0] unit;   // bit 0 is the mode value on ROW_MODE rows
    logic              last;
    row_check_e        check;
    logic [UNIT_W-1:0] want;
  } dir_row_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              text_end;
    logic              run_last;
  } cyr_unit_t;

  localparam dir_row_t DIRECTED [27] = '{
    '{ROW_ITEM, 16'h0061, 1'b1, CHK_ONE,   16'h0430},  // a
    '{ROW_ITEM, 16'h0041, 1'b1, CHK_ONE,   16'h0410},  // A, capital letter out
    '{ROW_ITEM, 16'hFFFF, 1'b1, CHK_ONE,   16'hFFFF},  // no key, raw unit
    '{ROW_ITEM, 16'h0000, 1'b1, CHK_ONE,   16'h0000},
    '{ROW_ITEM, 16'h0053, 1'b0, CHK_NONE,  16'h0000},  // SHCH: longest key
    '{ROW_ITEM, 16'h0048, 1'b0, CHK_NONE,  16'h0000},
    '{ROW_ITEM, 16'h0043, 1'b0, CHK_NONE,  16'h0000},
    '{ROW_ITEM, 16'h0048, 1'b1, CHK_ONE,   16'h0429},
    '{ROW_ITEM, 16'h0073, 1'b0, CHK_MODEL, 16'h0000},  // sch on drain
    '{ROW_ITEM, 16'h0063, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h0068, 1'b1, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h0065, 1'b0, CHK_MODEL, 16'h0000},  // e' ja Yo w acute
    '{ROW_ITEM, 16'h0027, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h006A, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h0061, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h0059, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h006F, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h0077, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h00B4, 1'b1, CHK_MODEL, 16'h0000},
    '{ROW_MODE, 16'h0001, 1'b0, CHK_NONE,  16'h0000},
    '{ROW_ITEM, 16'h0020, 1'b1, CHK_ONE,   16'h005F},  // space to underscore
    '{ROW_ITEM, 16'h0071, 1'b1, CHK_ONE,   16'h0051},  // q uppercased
    '{ROW_ITEM, 16'h0450, 1'b0, CHK_MODEL, 16'h0000},  // Cyrillic raw, upper
    '{ROW_ITEM, 16'h045F, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h007A, 1'b0, CHK_MODEL, 16'h0000},
    '{ROW_ITEM, 16'h0068, 1'b1, CHK_MODEL, 16'h0000},
    '{ROW_MODE, 16'h0000, 1'b0, CHK_NONE,  16'h0000}
  };

  // key table; "\264" is the acute accent
  string key_txt [N_KEYS] = '{
    "a", "b", "v", "g", "d", "e", "jo", "yo", "zh", "z",
    "i", "j", "k", "l", "m", "n", "o", "p", "r", "s",
    "t", "u", "f", "h", "x", "c", "sh", "sch", "w", "shch",
    "ch", "y", "\264", "'", "e'", "je", "ju", "yu", "ja", "ya"
  };
  logic [UNIT_W-1:0] key_letter [N_KEYS] = '{
    16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434,
    16'h0435, 16'h0451, 16'h0451, 16'h0436, 16'h0437,
    16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C,
    16'h043D, 16'h043E, 16'h043F, 16'h0440, 16'h0441,
    16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0445,
    16'h0446, 16'h0448, 16'h0449, 16'h0449, 16'h0449,
    16'h0447, 16'h044B, 16'h044A, 16'h044C, 16'h044D,
    16'h044D, 16'h044E, 16'h044E, 16'h044F, 16'h044F
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [UNIT_W-1:0] s_tdata;
  logic              s_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic [UNIT_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  // predictor state
  logic [UNIT_W-1:0] pend_units [WIN];
  int                pend_count;
  logic              fname_mode;
  cyr_unit_t         expected_units [$];

  bit quiet;
  int n_sent, n_texts, n_checked, n_errors, idle_cycles;

  latin_to_cyrillic_transliterator #(.WINDOW(WIN)) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [UNIT_W-1:0] fold_lower(input logic [UNIT_W-1:0] c);
    return (c >= 16'h0041 && c <= 16'h005A) ? c + 16'h0020 : c;
  endfunction

  function automatic logic [UNIT_W-1:0] raise_case(input logic [UNIT_W-1:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
    if (c >= 16'h0430 && c <= 16'h044F) return c - 16'h0020;
    if (c >= 16'h0450 && c <= 16'h045F) return c - 16'h0050;
    return c;
  endfunction

  // Longest key at the head of the window; consumes it and returns the letter, or the raw unit if no key matches.
  function automatic logic [UNIT_W-1:0] resolve_head();
    int                best_len;
    int                klen;
    int                avail;
    logic [UNIT_W-1:0] best;
    logic              hit;
    best_len = 0;
    best     = '0;
    avail    = (pend_count < KEY_MAX) ? pend_count : KEY_MAX;
    for (int k = 0; k < N_KEYS; k++) begin
      klen = key_txt[k].len();
      hit  = (klen > best_len) && (klen <= avail);
      for (int j = 0; j < klen && hit; j++)
        if (fold_lower(pend_units[j]) != {8'h00, key_txt[k][j]}) hit = 1'b0;
      if (hit) begin
        best_len = klen;
        best     = key_letter[k];
      end
    end
    if (best_len == 0) begin
      best     = pend_units[0];
      best_len = 1;
    end else if (pend_units[0] >= 16'h0041 && pend_units[0] <= 16'h005A) begin
      best = raise_case(best);
    end
    for (int j = 0; j < WIN; j++)
      if (j + best_len < WIN) pend_units[j] = pend_units[j + best_len];
    pend_count -= best_len;
    return best;
  endfunction

  function automatic int transliterate_item(input logic [UNIT_W-1:0] unit,
                                            input logic last,
                                            output cyr_unit_t res [WIN]);
    logic [UNIT_W-1:0] made [WIN];
    logic [UNIT_W-1:0] c;
    int                n_made;
    int                n;
    n_made = 0;
    n      = 0;
    pend_units[pend_count] = unit;
    pend_count++;
    if (pend_count == WIN) begin
      made[n_made] = resolve_head();
      n_made++;
    end
    if (last) begin
      while (pend_count > 0 && n_made < WIN) begin
        made[n_made] = resolve_head();
        n_made++;
      end
    end
    for (int i = 0; i < n_made; i++) begin
      c = made[i];
      if (fname_mode && (c == CH_APOS || c == CH_ACUTE)) continue;
      if (fname_mode) c = raise_case((c == CH_SPACE) ? CH_UNDERSCORE : c);
      res[n] = '{c, 1'b0, 1'b0};
      n++;
    end
    // flags ride on the last unit actually emitted
    if (n > 0) begin
      res[n-1].text_end = last;
      res[n-1].run_last = 1'b1;
    end
    return n;
  endfunction

  function automatic logic [UNIT_W-1:0] noise_unit();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(16'h0020, 16'h007E));
      1: return 16'($urandom_range(16'h0400, 16'h045F));
      2: begin
        case ($urandom_range(0, 3))
          0: return CH_SPACE;
          1: return CH_APOS;
          2: return CH_ACUTE;
          default: return CH_UNDERSCORE;
        endcase
      end
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_item(input logic [UNIT_W-1:0] unit, input logic last,
                           input row_check_e check, input logic [UNIT_W-1:0] want);
    cyr_unit_t got [WIN];
    int        n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = unit;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = transliterate_item(unit, last, got);
    case (check)
      CHK_MODEL: for (int i = 0; i < n; i++) expected_units.push_back(got[i]);
      CHK_ONE:   expected_units.push_back('{want, last, 1'b1});
      default:   ;
    endcase
    n_sent++;
    if (last) n_texts++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // mode changes only with the pipeline drained
  task automatic write_mode(input logic value);
    while (expected_units.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    fname_mode = value;
  endtask

  // Texts built mostly from whole keys with random capitals, plus noise units.
  task automatic run_random_phase(input int n_items);
    logic [UNIT_W-1:0] text [$];
    logic [UNIT_W-1:0] u;
    logic              cap;
    int                target;
    int                k;
    while (n_items > 0) begin
      text.delete();
      target = $urandom_range(1, 10);
      while (text.size() < target) begin
        if ($urandom_range(0, 9) < 6) begin
          k   = $urandom_range(0, N_KEYS - 1);
          cap = ($urandom_range(0, 2) == 0);
          for (int j = 0; j < key_txt[k].len(); j++) begin
            u = {8'h00, key_txt[k][j]};
            if (cap && (j == 0 || $urandom_range(0, 1) == 1)) u = raise_case(u);
            text.push_back(u);
          end
        end else begin
          text.push_back(noise_unit());
        end
      end
      while (text.size() > n_items) void'(text.pop_back());
      foreach (text[i]) send_item(text[i], i == text.size() - 1, CHK_MODEL, '0);
      n_items -= text.size();
    end
  endtask

  // output side: random stall bursts, none in the quiet phase
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyr_unit_t want;
    if (rst_n && m_tvalid && m_tready) begin
      n_checked++;
      if (expected_units.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: unexpected unit %h text_end %b run_last %b",
                   m_tdata, m_tlast, m_tuser);
      end else begin
        want = expected_units.pop_front();
        if (m_tdata !== want.unit || m_tlast !== want.text_end ||
            m_tuser !== want.run_last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("ERROR: expected %h/%b/%b, got %h/%b/%b (unit/text_end/run_last)",
                     want.unit, want.text_end, want.run_last, m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d units still expected",
                 STALL_LIMIT, expected_units.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    quiet       = 1'b0;
    pend_count  = 0;
    fname_mode  = 1'b0;
    n_sent      = 0;
    n_texts     = 0;
    n_checked   = 0;
    n_errors    = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_mode(1'b0);
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_MODE)
        write_mode(DIRECTED[r].unit[0]);
      else
        send_item(DIRECTED[r].unit, DIRECTED[r].last, DIRECTED[r].check, DIRECTED[r].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_mode(~ph[0]);
      quiet = (ph == N_PHASES - 1);
      run_random_phase(RAND_ITEMS / N_PHASES);
    end

    while (expected_units.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Run: %0d units in %0d texts sent, %0d converted units checked, %0d errors",
             n_sent, n_texts, n_checked, n_errors);
    $display("Run: plain and file-name modes, key and raw paths, end-of-text drains, stalls");
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
